FILE: rtl/bnfpa_pkg.sv
// Package for the bitmap next-fit page allocator: sizes, action codes, sequencer states.
// Used by the top level.
`default_nettype none
package bnfpa_pkg;
	localparam int MAX_PAGES  = 131072;
	localparam int WORD_BITS  = 32;
	localparam int MAP_WORDS  = MAX_PAGES / WORD_BITS;
	localparam int WIDX_W     = $clog2(MAP_WORDS);

	typedef enum logic [1:0] {
		ACT_CLEAR   = 2'd0,
		ACT_RESERVE = 2'd1,
		ACT_ALLOC   = 2'd2,
		ACT_FREE    = 2'd3
	} action_t;

	localparam logic CFG_BASE  = 1'b0;
	localparam logic CFG_PAGES = 1'b1;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_MARK_RD,
		ST_MARK_WAIT,
		ST_MARK_WR,
		ST_SRCH_START,
		ST_SRCH_RD,
		ST_SRCH_WAIT,
		ST_SRCH_CHK,
		ST_DONE
	} state_t;
endpackage
`default_nettype wire

FILE: rtl/bnfpa_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none
module bnfpa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// One access a cycle: write or registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

FILE: rtl/bitmap_next_fit_page_allocator_core.sv
// Top level of the bitmap next-fit page allocator: handshakes, sequencer and map RAM.
// Depends on bnfpa_pkg and bnfpa_ram.
`default_nettype none
// One busy bit per page is held in a 4096 x 32 RAM with one port, and one
// small sequencer walks it one page a step (read, wait, then check or write):
// clear zeroes every word of the map, reserve and free visit each page in the
// range, and allocate probes pages from each candidate start over at most two
// passes of the window, then marks busy each page of the run that it finds.
// After reset a clearing pass runs before the first item is accepted. Each
// action returns one result, held in an output register until it is
// transferred; no new item is accepted while a result waits.
module bitmap_next_fit_page_allocator_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  action,
	input  wire logic [31:0] address,
	input  wire logic [17:0] count,
	input  wire logic [31:0] size,
	input  wire logic [31:0] align,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      alloc_address,
	output logic             ok,
	output logic [17:0]      free_count
);
	import bnfpa_pkg::*;

	state_t state_q, state_d;
	logic [19:0] base_q;
	logic [17:0] pages_q;
	logic [18:0] free_q, free_d;
	logic [17:0] cursor_q, cursor_d;
	logic [1:0]  act_q;
	logic [18:0] pg_q, pg_d;
	logic [18:0] last_q, last_d;
	logic [18:0] run_q, run_d;
	logic [17:0] cnt_q;
	logic [31:0] amask_q;
	logic        pass2_q, pass2_d;
	logic        out_valid_q, out_valid_d;
	logic [31:0] res_addr_q, res_addr_d;
	logic        res_ok_q, res_ok_d;
	logic        busy_val;
	logic [WIDX_W-1:0] ram_addr;
	logic        ram_we;
	logic [31:0] ram_wdata, ram_rdata;
	logic [WIDX_W-1:0] clr_q, clr_d;
	logic [18:0] np;
	logic [31:0] pb;
	logic [31:0] win_end;
	logic [31:0] end_b, base_c;
	logic [31:0] last_b;
	logic [31:0] fr_off;
	logic [19:0] fr_pg;
	logic [31:0] a_in;
	logic [31:0] a_m1;
	logic [32:0] rnd_sum;
	logic [31:0] rounded;
	logic [18:0] rnd_src;
	logic        in_acc;

	assign np      = (pages_q > 18'(MAX_PAGES - 1)) ? 19'(MAX_PAGES) : {1'b0, pages_q};
	assign pb      = {base_q, 12'h000};
	assign win_end = pb + {2'b00, np[17:0], 12'h000};
	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE) && !out_valid_q;
	assign in_acc    = in_valid && in_ready;

	// Reserve bounds.
	assign end_b  = address + size;
	assign base_c = (address < pb) ? pb : address;
	assign last_b = ((end_b + 32'hFFF) & 32'hFFFF_F000) - pb;

	// Free start page.
	assign fr_off = address - pb;
	assign fr_pg  = fr_off[31:12];

	// Alignment mask from the input.
	assign a_in = ({12'd0, align[31:12]} == 32'd0) ? 32'd1 : {12'd0, align[31:12]};
	assign a_m1 = a_in - 32'd1;

	// Round-up unit for search starts.
	assign rnd_sum = {14'd0, rnd_src} + {1'b0, amask_q};
	assign rounded = rnd_sum[31:0] & ~amask_q;

	assign busy_val = ram_rdata[pg_q[4:0]];

	bnfpa_ram #(.WIDTH(WORD_BITS), .DEPTH(MAP_WORDS)) u_map (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	// Configuration registers and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			base_q      <= '0;
			pages_q     <= 18'(MAX_PAGES);
			free_q      <= 19'(MAX_PAGES);
			cursor_q    <= '0;
			out_valid_q <= 1'b0;
			clr_q       <= '0;
		end else begin
			state_q     <= state_d;
			free_q      <= free_d;
			cursor_q    <= cursor_d;
			out_valid_q <= out_valid_d;
			clr_q       <= clr_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_BASE:  base_q  <= cfg_data[19:0];
					CFG_PAGES: pages_q <= cfg_data[17:0];
					default:   ;
				endcase
			end
		end
	end

	// Item payload and working registers.
	always_ff @(posedge clk) begin
		pg_q       <= pg_d;
		last_q     <= last_d;
		run_q      <= run_d;
		pass2_q    <= pass2_d;
		res_addr_q <= res_addr_d;
		res_ok_q   <= res_ok_d;
		if (in_acc) begin
			act_q   <= action;
			cnt_q   <= count;
			amask_q <= a_m1;
		end
	end

	// Sequencer: next state and RAM control.
	always_comb begin
		state_d     = state_q;
		free_d      = free_q;
		cursor_d    = cursor_q;
		out_valid_d = out_valid_q;
		clr_d       = clr_q;
		pg_d        = pg_q;
		last_d      = last_q;
		run_d       = run_q;
		pass2_d     = pass2_q;
		res_addr_d  = res_addr_q;
		res_ok_d    = res_ok_q;
		ram_we      = 1'b0;
		ram_addr    = pg_q[16:5];
		ram_wdata   = ram_rdata;
		rnd_src     = pg_q;
		if (out_valid_q && out_ready) begin
			out_valid_d = 1'b0;
		end
		case (state_q)
			ST_INIT, ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_addr  = clr_q;
				ram_wdata = '0;
				clr_d     = clr_q + 1'b1;
				if (clr_q == WIDX_W'(MAP_WORDS - 1)) begin
					state_d = (state_q == ST_INIT) ? ST_IDLE : ST_DONE;
				end
			end
			ST_IDLE: begin
				if (in_acc) begin
					res_addr_d = '0;
					res_ok_d   = 1'b0;
					pass2_d    = 1'b0;
					state_d    = ST_DONE;
					case (action_t'(action))
						ACT_CLEAR: begin
							free_d   = np;
							cursor_d = '0;
							clr_d    = '0;
							state_d  = ST_CLEAR;
						end
						ACT_RESERVE: begin
							if (size != 32'd0 && end_b > pb && address < win_end) begin
								pg_d   = 19'(((base_c & 32'hFFFF_F000) - pb) >> 12);
								last_d = (last_b[31:12] > {1'b0, np}) ? np : last_b[30:12];
								state_d = ST_MARK_RD;
							end
						end
						ACT_ALLOC: begin
							if (count != 18'd0 && {1'b0, count} <= free_q) begin
								pg_d    = {1'b0, cursor_q};
								state_d = ST_SRCH_START;
							end
						end
						default: begin
							if (address >= pb && count != 18'd0 &&
								({1'b0, fr_pg} + {3'd0, count} <= {2'd0, np})) begin
								pg_d    = fr_pg[18:0];
								last_d  = fr_pg[18:0] + {1'b0, count};
								if (fr_pg[18:0] < {1'b0, cursor_q}) begin
									cursor_d = fr_pg[17:0];
								end
								state_d = ST_MARK_RD;
							end
						end
					endcase
				end
			end
			ST_MARK_RD: begin
				state_d = (pg_q < last_q) ? ST_MARK_WAIT : ST_DONE;
			end
			ST_MARK_WAIT: state_d = ST_MARK_WR;
			ST_MARK_WR: begin
				// Set or clear one bit, adjusting the free count when it changes.
				ram_we = 1'b1;
				if (act_q == ACT_FREE) begin
					ram_wdata[pg_q[4:0]] = 1'b0;
					if (busy_val) free_d = free_q + 19'd1;
				end else begin
					ram_wdata[pg_q[4:0]] = 1'b1;
					if (!busy_val && free_q != 19'd0) free_d = free_q - 19'd1;
				end
				pg_d    = pg_q + 19'd1;
				state_d = ST_MARK_RD;
			end
			ST_SRCH_START: begin
				// Round the candidate start and check it fits the window.
				pg_d  = rounded[18:0];
				run_d = '0;
				if ({1'b0, rounded} + {15'd0, cnt_q} > {14'd0, np} || rounded[31:19] != '0) begin
					if (!pass2_q) begin
						pass2_d = 1'b1;
						pg_d    = '0;
					end else begin
						state_d = ST_DONE;
					end
				end else begin
					state_d = ST_SRCH_RD;
				end
			end
			ST_SRCH_RD: begin
				ram_addr = 12'((pg_q + run_q) >> 5);
				state_d  = ST_SRCH_WAIT;
			end
			ST_SRCH_WAIT: begin
				ram_addr = 12'((pg_q + run_q) >> 5);
				state_d  = ST_SRCH_CHK;
			end
			ST_SRCH_CHK: begin
				ram_addr = 12'((pg_q + run_q) >> 5);
				if (ram_rdata[5'(pg_q + run_q)]) begin
					pg_d    = pg_q + run_q + 19'd1;
					state_d = ST_SRCH_START;
				end else if (run_q + 19'd1 == {1'b0, cnt_q}) begin
					// Run found: mark it through the shared mark loop.
					res_ok_d   = 1'b1;
					res_addr_d = pb + {1'b0, pg_q, 12'h000};
					cursor_d   = 18'(pg_q + {1'b0, cnt_q});
					last_d     = pg_q + {1'b0, cnt_q};
					free_d     = (free_q >= {1'b0, cnt_q}) ? free_q - {1'b0, cnt_q} : '0;
					pass2_d    = 1'b1;
					state_d    = ST_MARK_RD;
					run_d      = '0;
				end else begin
					run_d   = run_q + 19'd1;
					state_d = ST_SRCH_RD;
				end
			end
			ST_DONE: begin
				out_valid_d = 1'b1;
				state_d     = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
		// During an allocation's marking the count was already taken.
		if (state_q == ST_MARK_WR && act_q == ACT_ALLOC) begin
			free_d = free_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign alloc_address = res_addr_q;
	assign ok            = res_ok_q;
	assign free_count    = free_q[17:0];
endmodule
`default_nettype wire
